@@ design/cdrb_pkg.sv @@
// ----------------------------------------------------------------------------
// cdrb_pkg: shared types and constants of the chunk-drop byte ring buffer
// Holds the input item and result structs, opcode and status codes, and the
// default sizes handed to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cdrb_pkg;

	// default sizes
	localparam int unsigned DEPTH_DEF        = 4096;
	localparam int unsigned MAX_READ_RUN_DEF = 64;

	// opcodes as they arrive on the input stream
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_IGNORE = 2'd3;

	// result status codes
	localparam logic [2:0] STAT_READ_BYTE  = 3'd0;
	localparam logic [2:0] STAT_CHUNK_OK   = 3'd1;
	localparam logic [2:0] STAT_CHUNK_DROP = 3'd2;
	localparam logic [2:0] STAT_READ_EMPTY = 3'd3;
	localparam logic [2:0] STAT_CLEARED    = 3'd4;

	// item kind after classification in the front end
	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	// one queued item
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [11:0] length;
		logic        first_of_chunk;
		logic        last_of_chunk;
	} item_t;

	// one result beat
	typedef struct packed {
		logic [7:0]  read_byte;
		logic [2:0]  status;
		logic        run_last;
		logic [11:0] used_count;
		logic [31:0] dropped_total;
	} result_t;

endpackage

`default_nettype wire

@@ design/cdrb_ram.sv @@
// ----------------------------------------------------------------------------
// cdrb_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds while
// the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module cdrb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ design/cdrb_front.sv @@
// ----------------------------------------------------------------------------
// cdrb_front: input beat classification and item queue
// Decodes the opcode of each accepted beat, drops unknown opcodes, and keeps
// up to two items queued for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cdrb_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire [1:0]         in_op,
	input  wire [7:0]         in_data_byte,
	input  wire [11:0]        in_length,
	input  wire               in_first,
	input  wire               in_last,
	output logic              item_valid,
	output cdrb_pkg::item_t   item,
	input  wire               item_pop
);

	logic [1:0]      cnt_q;
	logic            wp_q;
	logic            rp_q;
	cdrb_pkg::item_t slot_q [2];
	cdrb_pkg::item_t new_item;
	logic            keep;
	logic            push;

	// opcode decode
	always_comb begin
		new_item.data_byte      = in_data_byte;
		new_item.length         = in_length;
		new_item.first_of_chunk = in_first;
		new_item.last_of_chunk  = in_last;
		new_item.kind           = cdrb_pkg::KIND_WRITE;
		keep                    = 1'b1;
		unique case (in_op)
			cdrb_pkg::OP_WRITE: new_item.kind = cdrb_pkg::KIND_WRITE;
			cdrb_pkg::OP_READ:  new_item.kind = cdrb_pkg::KIND_READ;
			cdrb_pkg::OP_CLEAR: new_item.kind = cdrb_pkg::KIND_CLEAR;
			default:            keep          = 1'b0;
		endcase
	end

	assign in_ready   = (cnt_q != 2'd2);
	assign push       = in_valid && in_ready && keep;
	assign item_valid = (cnt_q != 2'd0);
	assign item       = slot_q[rp_q];

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (item_pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !item_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && item_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// queue slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= new_item;
		end
	end

endmodule

`default_nettype wire

@@ design/cdrb_back.sv @@
// ----------------------------------------------------------------------------
// cdrb_back: ring buffer engine
// Executes queued items against the byte ring: chunk admission, stores,
// read runs and clears. Results leave through a one-beat output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdrb_back #(
	parameter int unsigned DEPTH        = cdrb_pkg::DEPTH_DEF,
	parameter int unsigned MAX_READ_RUN = cdrb_pkg::MAX_READ_RUN_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                item_valid,
	input  cdrb_pkg::item_t    item,
	output logic               item_pop,
	output logic               res_valid,
	output cdrb_pkg::result_t  res,
	input  wire                res_ready
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = ((AW > 12) ? AW : 12) + 1;
	localparam int unsigned RW = $clog2(MAX_READ_RUN + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     rd_pos_q;
	logic [AW-1:0]     wr_pos_q;
	logic [AW-1:0]     used_q;
	logic              chunk_q;
	logic [31:0]       dropped_q;
	logic [RW-1:0]     rcnt_q;
	logic              out_valid_q;
	cdrb_pkg::result_t out_q;

	logic              out_free;
	logic              out_load;
	logic [CW-1:0]     len_w;
	logic [CW-1:0]     used_w;
	logic [CW-1:0]     free_w;
	logic [CW-1:0]     cnt_a;
	logic [CW-1:0]     cnt_w;
	logic              accept_first;
	logic              acc_now;
	logic              room;
	logic              store;
	logic [32:0]       drop_sum;
	logic [31:0]       dropped_d;
	logic [AW-1:0]     wr_next;
	logic [AW-1:0]     rd_next;
	logic [AW-1:0]     used_inc;
	logic [AW-1:0]     used_dec;
	logic [AW+11:0]    used_inc_x;
	logic [AW+11:0]    used_dec_x;
	logic [AW+11:0]    used_cur_x;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [7:0]        ram_rdata;

	assign out_free  = !out_valid_q || res_ready;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// position and occupancy arithmetic
	assign wr_next  = (wr_pos_q == AW'(DEPTH - 1)) ? '0 : wr_pos_q + AW'(1);
	assign rd_next  = (rd_pos_q == AW'(DEPTH - 1)) ? '0 : rd_pos_q + AW'(1);
	assign used_inc = used_q + AW'(1);
	assign used_dec = used_q - AW'(1);

	// used count reported on 12 bits
	assign used_inc_x = {12'b0, (store ? used_inc : used_q)};
	assign used_dec_x = {12'b0, used_dec};
	assign used_cur_x = {12'b0, used_q};

	// chunk admission on the first byte
	assign len_w        = CW'(item.length);
	assign used_w       = CW'(used_q);
	assign free_w       = CW'(DEPTH - 1) - used_w;
	assign accept_first = (item.length != 12'd0) && (len_w <= free_w);
	assign acc_now      = item.first_of_chunk ? accept_first : chunk_q;
	assign room         = (used_q != AW'(DEPTH - 1));
	assign store        = acc_now && room;

	// saturating dropped-byte total
	assign drop_sum  = {1'b0, dropped_q} + 33'(item.length);
	assign dropped_d = (item.first_of_chunk && !accept_first) ?
		(drop_sum[32] ? 32'hFFFF_FFFF : drop_sum[31:0]) : dropped_q;

	// read run length
	assign cnt_a = (len_w < CW'(MAX_READ_RUN)) ? len_w : CW'(MAX_READ_RUN);
	assign cnt_w = (cnt_a < used_w) ? cnt_a : used_w;

	// a result beat enters the output register
	assign out_load = ((state_q == ST_IDLE) && item_pop &&
		((item.kind != cdrb_pkg::KIND_READ) || (cnt_w == '0))) ||
		((state_q == ST_READ) && out_free);

	// pop and ram read control
	always_comb begin
		item_pop  = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = rd_pos_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && out_free) begin
					item_pop = 1'b1;
					ram_re   = (item.kind == cdrb_pkg::KIND_READ) && (cnt_w != '0);
				end
			end
			ST_READ: begin
				if (out_free && (rcnt_q != RW'(1))) begin
					ram_re    = 1'b1;
					ram_raddr = rd_next;
				end
			end
			default: begin
			end
		endcase
	end

	cdrb_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    ((state_q == ST_IDLE) && item_pop && (item.kind == cdrb_pkg::KIND_WRITE)
		        && store),
		.waddr (wr_pos_q),
		.wdata (item.data_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// engine state and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_pos_q    <= '0;
			wr_pos_q    <= '0;
			used_q      <= '0;
			chunk_q     <= 1'b0;
			dropped_q   <= '0;
			rcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !res_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (item_pop) begin
						unique case (item.kind)
							cdrb_pkg::KIND_WRITE: begin
								dropped_q <= dropped_d;
								chunk_q   <= acc_now && !item.last_of_chunk;
								if (store) begin
									wr_pos_q <= wr_next;
									used_q   <= used_inc;
								end
							end
							cdrb_pkg::KIND_READ: begin
								if (cnt_w != '0) begin
									rcnt_q  <= RW'(cnt_w);
									state_q <= ST_READ;
								end
							end
							cdrb_pkg::KIND_CLEAR: begin
								rd_pos_q <= '0;
								wr_pos_q <= '0;
								used_q   <= '0;
								chunk_q  <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					if (out_free) begin
						rd_pos_q <= rd_next;
						used_q   <= used_dec;
						rcnt_q   <= rcnt_q - RW'(1);
						if (rcnt_q == RW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (item_pop) begin
					out_q.read_byte <= 8'd0;
					out_q.run_last  <= 1'b1;
					case (item.kind)
						cdrb_pkg::KIND_WRITE: begin
							out_q.status        <= acc_now ? cdrb_pkg::STAT_CHUNK_OK :
							                                 cdrb_pkg::STAT_CHUNK_DROP;
							out_q.used_count    <= used_inc_x[11:0];
							out_q.dropped_total <= dropped_d;
						end
						cdrb_pkg::KIND_READ: begin
							out_q.status        <= cdrb_pkg::STAT_READ_EMPTY;
							out_q.used_count    <= used_cur_x[11:0];
							out_q.dropped_total <= dropped_q;
						end
						default: begin
							out_q.status        <= cdrb_pkg::STAT_CLEARED;
							out_q.used_count    <= 12'd0;
							out_q.dropped_total <= dropped_q;
						end
					endcase
				end
			end
			ST_READ: begin
				if (out_free) begin
					out_q.read_byte     <= ram_rdata;
					out_q.status        <= cdrb_pkg::STAT_READ_BYTE;
					out_q.run_last      <= (rcnt_q == RW'(1));
					out_q.used_count    <= used_dec_x[11:0];
					out_q.dropped_total <= dropped_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ design/chunk_drop_byte_ring_buffer_top.sv @@
// Byte ring buffer with all-or-nothing chunk writes. Each input beat is a
// write byte, a read request or a clear; a chunk is stored only when the
// nonzero length on its first byte fits the free space (capacity DEPTH-1),
// else its bytes are discarded and counted in a saturating dropped-byte
// total. A write byte or a clear yields one result beat; a read request
// first starts the ring RAM's registered read and then yields one byte per
// cycle while the output is not stalled, paced by the single RAM read port.
// A two-entry input queue lets new beats be taken while the engine works or
// the output stalls. No clearing pass after reset.
// ----------------------------------------------------------------------------
// chunk_drop_byte_ring_buffer_top: chunk-drop byte ring buffer
// Stream in, stream out; front end queues classified items, back end runs
// them against the ring RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module chunk_drop_byte_ring_buffer_top #(
	parameter int unsigned DEPTH        = cdrb_pkg::DEPTH_DEF,
	parameter int unsigned MAX_READ_RUN = cdrb_pkg::MAX_READ_RUN_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [23:0] s_axis_tdata,  // data_byte[7:0], length[19:8], zero pad
	input  wire  [2:0]  s_axis_tuser,  // operation[1:0], first_of_chunk[2]
	input  wire         s_axis_tlast,  // last_of_chunk
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [55:0] m_axis_tdata,  // read_byte[7:0], used_count[19:8],
	                                   // dropped_total[51:20], zero pad
	output logic [2:0]  m_axis_tuser,  // status
	output logic        m_axis_tlast   // run_last
);

	logic              item_valid;
	cdrb_pkg::item_t   item;
	logic              item_pop;
	cdrb_pkg::result_t res;

	cdrb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_op        (s_axis_tuser[1:0]),
		.in_data_byte (s_axis_tdata[7:0]),
		.in_length    (s_axis_tdata[19:8]),
		.in_first     (s_axis_tuser[2]),
		.in_last      (s_axis_tlast),
		.item_valid   (item_valid),
		.item         (item),
		.item_pop     (item_pop)
	);

	cdrb_back #(
		.DEPTH        (DEPTH),
		.MAX_READ_RUN (MAX_READ_RUN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.res_valid  (m_axis_tvalid),
		.res        (res),
		.res_ready  (m_axis_tready)
	);

	// output beat packing
	assign m_axis_tdata = {4'b0, res.dropped_total, res.used_count, res.read_byte};
	assign m_axis_tuser = res.status;
	assign m_axis_tlast = res.run_last;

`ifndef SYNTHESIS
	// only read-byte beats can be in the middle of a run
	a_single_beat_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != cdrb_pkg::STAT_READ_BYTE)) |-> m_axis_tlast)
		else $error("non-read result without run_last");

	// non-read results carry a zero byte
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != cdrb_pkg::STAT_READ_BYTE))
		|-> (m_axis_tdata[7:0] == 8'd0))
		else $error("non-read result with nonzero byte");

	// a clear leaves the ring empty
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == cdrb_pkg::STAT_CLEARED))
		|-> (m_axis_tdata[19:8] == 12'd0))
		else $error("clear result with nonzero used count");
`endif

endmodule

`default_nettype wire

@@ tb/chunk_drop_byte_ring_buffer_top_tb.sv @@
// ----------------------------------------------------------------------------
// chunk_drop_byte_ring_buffer_top_tb: self-checking bench for the byte ring
// Drives write, read, clear and ignored beats onto the input stream, tracks a
// private copy of the ring to work out every result beat, and compares each
// output beat field by field in order. A short table of directed beats comes
// first, then random traffic under several patterns of input gaps and output
// back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module chunk_drop_byte_ring_buffer_top_tb;

	import cdrb_pkg::*;

	localparam int unsigned RING_DEPTH = DEPTH_DEF;
	localparam int unsigned RUN_CAP    = MAX_READ_RUN_DEF;
	localparam int          PHASE_BEATS = 97;

	// one directed beat, with its result typed in where it is obvious
	typedef struct {
		logic [1:0]  op;
		logic [7:0]  data;
		logic [11:0] len;
		logic        first;
		logic        last;
		bit          pinned;
		result_t     want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// private copy of the ring
	logic [7:0]  ring_mem [RING_DEPTH];
	int unsigned rd_ptr;
	int unsigned wr_ptr;
	bit          chunk_open;
	logic [31:0] drop_sum;

	result_t     owed_results[$];
	stim_row_t   directed_rows[$];
	bit          pin_on;
	result_t     pin_want;
	int          err_count;
	int          result_idx;
	int          beats_sent;
	int          send_idle;
	int          recv_stall;

	chunk_drop_byte_ring_buffer_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("chunk_drop_byte_ring_buffer_top_tb: errors");
		$finish;
	end

	function automatic int unsigned ring_used();
		return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
	endfunction

	function automatic void owe(logic [7:0] rbyte, logic [2:0] st, logic lst);
		result_t r;
		r.read_byte     = rbyte;
		r.status        = st;
		r.run_last      = lst;
		r.used_count    = 12'(ring_used());
		r.dropped_total = drop_sum;
		owed_results.push_back(r);
	endfunction

	// work out the result beats of one accepted input beat
	task automatic ring_track(input logic [1:0] op, input logic [7:0] data,
			input logic [11:0] len, input logic first, input logic last);
		int unsigned room;
		int unsigned count;
		logic [32:0] sum;
		logic [2:0]  st;
		case (op)
			OP_WRITE: begin
				if (first) begin
					room = RING_DEPTH - 1 - ring_used();
					if (len != 0 && len <= room) begin
						chunk_open = 1'b1;
					end else begin
						chunk_open = 1'b0;
						sum = {1'b0, drop_sum} + {21'd0, len};
						drop_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					end
				end
				if (chunk_open) begin
					// bytes past a full ring vanish but still read as accepted
					if (ring_used() < RING_DEPTH - 1) begin
						ring_mem[wr_ptr] = data;
						wr_ptr = (wr_ptr + 1) % RING_DEPTH;
					end
					st = STAT_CHUNK_OK;
				end else begin
					st = STAT_CHUNK_DROP;
				end
				if (last)
					chunk_open = 1'b0;
				owe(8'h00, st, 1'b1);
			end
			OP_READ: begin
				count = {20'd0, len};
				if (count > RUN_CAP)
					count = RUN_CAP;
				if (count > ring_used())
					count = ring_used();
				if (count == 0) begin
					owe(8'h00, STAT_READ_EMPTY, 1'b1);
				end else begin
					for (int unsigned i = 0; i < count; i++) begin
						st = STAT_READ_BYTE;
						rd_ptr = (rd_ptr + 1) % RING_DEPTH;
						owe(ring_mem[(rd_ptr + RING_DEPTH - 1) % RING_DEPTH], st,
							i + 1 == count);
					end
				end
			end
			OP_CLEAR: begin
				rd_ptr     = 0;
				wr_ptr     = 0;
				chunk_open = 1'b0;
				owe(8'h00, STAT_CLEARED, 1'b1);
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		err_count++;
		if (err_count <= 40)
			$display("%0t ns result %0d %s: got 0x%0h expected 0x%0h",
				$time, result_idx, what, got, want);
	endtask

	// input side: predict on every accepted beat
	always @(posedge clk) begin
		int n0;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			n0 = owed_results.size();
			ring_track(s_axis_tuser[1:0], s_axis_tdata[7:0], s_axis_tdata[19:8],
				s_axis_tuser[2], s_axis_tlast);
			if (pin_on && owed_results.size() == n0 + 1) begin
				void'(owed_results.pop_back());
				owed_results.push_back(pin_want);
			end
		end
	end

	// output side: compare each accepted result beat with the oldest one owed
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.read_byte     = m_axis_tdata[7:0];
			got.used_count    = m_axis_tdata[19:8];
			got.dropped_total = m_axis_tdata[51:20];
			got.status        = m_axis_tuser;
			got.run_last      = m_axis_tlast;
			if (owed_results.size() == 0) begin
				report_mismatch("unexpected beat, status", 32'(got.status), 0);
			end else begin
				want = owed_results.pop_front();
				if (got.read_byte !== want.read_byte)
					report_mismatch("read_byte", 32'(got.read_byte), 32'(want.read_byte));
				if (got.status !== want.status)
					report_mismatch("status", 32'(got.status), 32'(want.status));
				if (got.run_last !== want.run_last)
					report_mismatch("run_last", 32'(got.run_last), 32'(want.run_last));
				if (got.used_count !== want.used_count)
					report_mismatch("used_count", 32'(got.used_count),
						32'(want.used_count));
				if (got.dropped_total !== want.dropped_total)
					report_mismatch("dropped_total", got.dropped_total, want.dropped_total);
			end
			result_idx++;
		end
	end

	// output back-pressure
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall);
	end

	// drive one beat at a falling edge and hold it until taken
	task automatic send_beat(input logic [1:0] op, input logic [7:0] data,
			input logic [11:0] len, input logic first, input logic last);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'h0, len, data};
		s_axis_tuser  <= {first, op};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		if (op != OP_IGNORE)
			beats_sent++;
	endtask

	// a chunk declaring 'declared' bytes and carrying 'n_bytes'; reads may slip in
	task automatic send_chunk(input int declared, input int n_bytes, input bit close,
			input bit mix);
		for (int k = 0; k < n_bytes; k++) begin
			if (mix && k > 0 && $urandom_range(99) < 6)
				send_beat(OP_READ, 8'($urandom), 12'($urandom_range(40, 0)),
					1'($urandom), 1'($urandom));
			send_beat(OP_WRITE, 8'($urandom),
				(k == 0) ? declared[11:0] : 12'($urandom_range(4095, 0)),
				k == 0, close && (k == n_bytes - 1));
		end
	endtask

	task automatic add_row(input logic [1:0] op, input logic [7:0] data,
			input logic [11:0] len, input logic first, input logic last, input bit pinned,
			input logic [7:0] rbyte, input logic [2:0] st, input logic [11:0] used,
			input logic [31:0] dropped);
		stim_row_t row;
		row.op     = op;
		row.data   = data;
		row.len    = len;
		row.first  = first;
		row.last   = last;
		row.pinned = pinned;
		row.want   = '{read_byte: rbyte, status: st, run_last: 1'b1,
			used_count: used, dropped_total: dropped};
		directed_rows.push_back(row);
	endtask

	initial begin
		int pick;
		int n;
		int phase_start;
		stim_row_t row;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		s_axis_tlast  = 1'b0;
		send_idle     = 0;
		recv_stall    = 0;
		pin_on        = 1'b0;
		err_count     = 0;
		result_idx    = 0;
		beats_sent    = 0;
		rd_ptr        = 0;
		wr_ptr        = 0;
		chunk_open    = 1'b0;
		drop_sum      = '0;

		// directed beats: reads on an empty ring, stray and zero-length writes,
		// the full-length chunk, a drop, short and over-long chunks, the ignored
		// opcode, a capped read, and a clear in the middle of a chunk;
		// the expected fields of unpinned rows are not used
		add_row(OP_READ,  8'h00, 12'd5,    1'b0, 1'b0, 1'b1,
			8'h00, STAT_READ_EMPTY, 12'd0, 32'd0);
		add_row(OP_READ,  8'hFF, 12'd0,    1'b1, 1'b1, 1'b1,
			8'h00, STAT_READ_EMPTY, 12'd0, 32'd0);
		add_row(OP_WRITE, 8'hAA, 12'd7,    1'b0, 1'b0, 1'b1,
			8'h00, STAT_CHUNK_DROP, 12'd0, 32'd0);
		add_row(OP_WRITE, 8'h33, 12'd0,    1'b1, 1'b1, 1'b1,
			8'h00, STAT_CHUNK_DROP, 12'd0, 32'd0);
		add_row(OP_WRITE, 8'hFF, 12'd4095, 1'b1, 1'b1, 1'b1,
			8'h00, STAT_CHUNK_OK,   12'd1, 32'd0);
		add_row(OP_WRITE, 8'h00, 12'd4095, 1'b1, 1'b0, 1'b1,
			8'h00, STAT_CHUNK_DROP, 12'd1, 32'd4095);
		add_row(OP_WRITE, 8'h55, 12'd0,    1'b0, 1'b1, 1'b1,
			8'h00, STAT_CHUNK_DROP, 12'd1, 32'd4095);
		add_row(OP_WRITE, 8'h00, 12'd3,    1'b1, 1'b0, 1'b0,
			8'h00, STAT_READ_BYTE,  12'd0, 32'd0);
		add_row(OP_WRITE, 8'h80, 12'd0,    1'b0, 1'b0, 1'b0,
			8'h00, STAT_READ_BYTE,  12'd0, 32'd0);
		add_row(OP_WRITE, 8'h7F, 12'hFFF,  1'b0, 1'b1, 1'b0,
			8'h00, STAT_READ_BYTE,  12'd0, 32'd0);
		add_row(OP_WRITE, 8'h01, 12'd2,    1'b1, 1'b0, 1'b0,
			8'h00, STAT_READ_BYTE,  12'd0, 32'd0);
		add_row(OP_WRITE, 8'h02, 12'd0,    1'b0, 1'b0, 1'b0,
			8'h00, STAT_READ_BYTE,  12'd0, 32'd0);
		add_row(OP_WRITE, 8'h04, 12'd0,    1'b0, 1'b0, 1'b0,
			8'h00, STAT_READ_BYTE,  12'd0, 32'd0);
		add_row(OP_WRITE, 8'h08, 12'd0,    1'b0, 1'b1, 1'b0,
			8'h00, STAT_READ_BYTE,  12'd0, 32'd0);
		add_row(OP_IGNORE, 8'hFF, 12'hFFF, 1'b1, 1'b1, 1'b0,
			8'h00, STAT_READ_BYTE,  12'd0, 32'd0);
		add_row(OP_READ,  8'h00, 12'd4095, 1'b0, 1'b0, 1'b0,
			8'h00, STAT_READ_BYTE,  12'd0, 32'd0);
		add_row(OP_WRITE, 8'h11, 12'd5,    1'b1, 1'b0, 1'b1,
			8'h00, STAT_CHUNK_OK,   12'd1, 32'd4095);
		add_row(OP_CLEAR, 8'h00, 12'd0,    1'b0, 1'b0, 1'b1,
			8'h00, STAT_CLEARED,    12'd0, 32'd4095);
		add_row(OP_WRITE, 8'h22, 12'd0,    1'b0, 1'b1, 1'b1,
			8'h00, STAT_CHUNK_DROP, 12'd0, 32'd4095);
		add_row(OP_WRITE, 8'h5A, 12'd1,    1'b1, 1'b1, 1'b1,
			8'h00, STAT_CHUNK_OK,   12'd1, 32'd4095);
		add_row(OP_READ,  8'h00, 12'd1,    1'b0, 1'b0, 1'b1,
			8'h5A, STAT_READ_BYTE,  12'd0, 32'd4095);
		add_row(OP_READ,  8'h00, 12'd64,   1'b0, 1'b0, 1'b1,
			8'h00, STAT_READ_EMPTY, 12'd0, 32'd4095);

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			row      = directed_rows[i];
			pin_on   = row.pinned;
			pin_want = row.want;
			send_beat(row.op, row.data, row.len, row.first, row.last);
		end
		pin_on = 1'b0;

		// random traffic under four gap and stall patterns
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 82; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 82; end
				default: begin send_idle = 24; recv_stall = 24; end
			endcase
			phase_start = beats_sent;
			while (beats_sent - phase_start < PHASE_BEATS) begin
				pick = $urandom_range(99);
				if (pick < 55) begin
					// well-formed chunk, mostly short
					n = ($urandom_range(99) < 85) ? $urandom_range(24, 1)
						: $urandom_range(200, 25);
					send_chunk(n, n, 1'b1, 1'b1);
				end else if (pick < 75) begin
					send_beat(OP_READ, 8'($urandom),
						($urandom_range(99) < 80) ? 12'($urandom_range(70, 0))
						: 12'($urandom_range(4095, 0)),
						1'($urandom), 1'($urandom));
				end else if (pick < 80) begin
					// any declared length, cut short
					send_chunk($urandom_range(4095, 0), $urandom_range(6, 1), 1'b1, 1'b0);
				end else if (pick < 85) begin
					// chunk left open or running past its declared length
					n = $urandom_range(12, 1);
					if ($urandom_range(1))
						send_chunk(n, $urandom_range(n, 1), 1'b0, 1'b0);
					else
						send_chunk(n, n + $urandom_range(5, 1), 1'b1, 1'b0);
				end else if (pick < 90) begin
					repeat ($urandom_range(3, 1))
						send_beat(OP_WRITE, 8'($urandom), 12'($urandom), 1'b0,
							1'($urandom));
				end else if (pick < 93) begin
					send_beat(OP_CLEAR, 8'($urandom), 12'($urandom), 1'($urandom),
						1'($urandom));
				end else if (pick < 96) begin
					send_beat(OP_IGNORE, 8'($urandom), 12'($urandom), 1'($urandom),
						1'($urandom));
				end else begin
					send_beat(2'($urandom_range(2, 0)), 8'($urandom), 12'($urandom),
						1'($urandom), 1'($urandom));
				end
			end
			s_axis_tvalid <= 1'b0;
			while (owed_results.size() != 0)
				@(negedge clk);
		end

		// let any stray beat show up before the verdict
		recv_stall = 0;
		repeat (100) @(negedge clk);
		if (owed_results.size() != 0)
			report_mismatch("results still owed", 0, owed_results.size());
		if (err_count == 0)
			$display("chunk_drop_byte_ring_buffer_top_tb: clean");
		else
			$display("chunk_drop_byte_ring_buffer_top_tb: errors");
		$finish;
	end

endmodule
